// File: rtl/dwt_pkg.sv
// ----------------------------------------------------------------------------
// dwt_pkg
// Types and constants shared by the dial wait timer modules.
// ----------------------------------------------------------------------------
package dwt_pkg;

    localparam int INTERVAL_W = 17;
    localparam int MINUTE_W   = 11;
    localparam int SECONDS_W  = 18;
    localparam int WD_W       = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [INTERVAL_W-1:0] DISCRETE_THRESHOLD = 17'd900;
    localparam logic [INTERVAL_W-1:0] WAIT_FIRST         = 17'd10;
    localparam logic [INTERVAL_W-1:0] WAIT_DEFAULT       = 17'd60;
    localparam logic [INTERVAL_W-1:0] WAIT_PWRSAVE       = 17'd600;
    localparam logic [WD_W-1:0]       WD_MARGIN          = 17'd300;
    localparam logic [WD_W-1:0]       WD_PWRSAVE         = WAIT_PWRSAVE + WD_MARGIN;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIAL_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWRSAVE_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWRSAVE_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWRSAVE_END   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_WAITING = 2'd1,
        ST_SIGNAL  = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef struct packed {
        logic [INTERVAL_W-1:0] dial_interval;
        logic                  monitor_mode;
        logic                  pwrsave_enable;
        logic [MINUTE_W-1:0]   pwrsave_start_min;
        logic [MINUTE_W-1:0]   pwrsave_end_min;
    } t_cfg;

    typedef struct packed {
        logic                op;
        logic                redial_request;
        logic                frame_ready;
        logic [MINUTE_W-1:0] now_minutes;
    } t_item;

    typedef struct packed {
        t_status                     status;
        logic signed [SECONDS_W-1:0] seconds_to_dial;
        logic                        watchdog_kick;
        logic [WD_W-1:0]             watchdog_seconds;
        logic                        inside_window;
    } t_result;

endpackage

// File: rtl/dial_wait_timer_power_save.sv
// ----------------------------------------------------------------------------
// dial_wait_timer_power_save
// Wake timer that counts down seconds to the next modem dial.
// ----------------------------------------------------------------------------
// One transaction in, one result out. A start transaction (tuser 0) loads the
// wait and kicks the watchdog; a tick transaction (tuser 1) ends the wait on a
// redial request or (outside discrete mode) a ready frame, or counts one second
// down, reloading 600 s inside the power-save window in discrete mode with power
// save on when the count runs out. The block takes a new transaction every cycle
// unless the output stalls; each passes the input register, then the update logic
// into the output register, and the countdown state is updated as it leaves the
// input register. Configuration writes take effect on the next cycle.
module dial_wait_timer_power_save
    import dwt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] redial_request, [1] frame_ready, [12:2] now_minutes, [15:13] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] status, [19:2] seconds_to_dial, [20] watchdog_kick,
    // [37:21] watchdog_seconds, [38] inside_window, [39] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;
    logic    fire;
    logic    in_accept;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    dwt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dwt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.op             <= s_axis_tuser;
            r_in.redial_request <= s_axis_tdata[0];
            r_in.frame_ready    <= s_axis_tdata[1];
            r_in.now_minutes    <= s_axis_tdata[MINUTE_W+1:2];
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.inside_window, r_out.watchdog_seconds,
                            r_out.watchdog_kick, r_out.seconds_to_dial, r_out.status};

endmodule

// File: rtl/dwt_cfg.sv
// ----------------------------------------------------------------------------
// dwt_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dwt_cfg
    import dwt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DIAL_INTERVAL: r_cfg.dial_interval     <= i_cfg_data[INTERVAL_W-1:0];
                CFG_MONITOR_MODE:  r_cfg.monitor_mode      <= i_cfg_data[0];
                CFG_PWRSAVE_EN:    r_cfg.pwrsave_enable    <= i_cfg_data[0];
                CFG_PWRSAVE_START: r_cfg.pwrsave_start_min <= i_cfg_data[MINUTE_W-1:0];
                CFG_PWRSAVE_END:   r_cfg.pwrsave_end_min   <= i_cfg_data[MINUTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/dwt_core.sv
// ----------------------------------------------------------------------------
// dwt_core
// Countdown state and the per-transaction update: wait choice, dial signals,
// power-save window check and watchdog value.
// ----------------------------------------------------------------------------
module dwt_core
    import dwt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // remaining is at least one while a wait runs, so it stays unsigned here
    logic [INTERVAL_W-1:0] r_remaining, n_remaining;
    logic                  r_first, n_first;
    logic                  r_active, n_active;

    logic                  discrete;
    logic                  win_hit;
    logic [INTERVAL_W-1:0] wait_sel;
    logic [INTERVAL_W:0]   wd_sum;
    logic [INTERVAL_W-1:0] dec;
    t_result               res;

    assign discrete = i_cfg.dial_interval > DISCRETE_THRESHOLD;

    // window may wrap past midnight; empty when start equals end
    always_comb begin
        if (i_cfg.pwrsave_start_min < i_cfg.pwrsave_end_min) begin
            win_hit = (i_item.now_minutes > i_cfg.pwrsave_start_min) &&
                      (i_item.now_minutes <= i_cfg.pwrsave_end_min);
        end else if (i_cfg.pwrsave_end_min < i_cfg.pwrsave_start_min) begin
            win_hit = (i_item.now_minutes <= i_cfg.pwrsave_end_min) ||
                      (i_item.now_minutes > i_cfg.pwrsave_start_min);
        end else begin
            win_hit = 1'b0;
        end
    end

    always_comb begin
        if (r_first) begin
            wait_sel = WAIT_FIRST;
        end else if (i_cfg.monitor_mode) begin
            wait_sel = WAIT_DEFAULT;
        end else if (discrete) begin
            wait_sel = i_cfg.dial_interval;
        end else begin
            wait_sel = WAIT_DEFAULT;
        end
    end

    assign wd_sum = {1'b0, wait_sel} + {1'b0, WD_MARGIN};
    assign dec    = r_remaining - 1'b1;

    always_comb begin
        n_remaining          = r_remaining;
        n_first              = r_first;
        n_active             = r_active;
        res.status           = ST_IDLE;
        res.watchdog_kick    = 1'b0;
        res.watchdog_seconds = '0;
        res.inside_window    = 1'b0;
        if (!i_item.op) begin
            n_remaining          = wait_sel - 1'b1;
            n_first              = 1'b0;
            n_active             = 1'b1;
            res.status           = ST_WAITING;
            res.watchdog_kick    = 1'b1;
            res.watchdog_seconds = wd_sum[INTERVAL_W] ? '1 : wd_sum[WD_W-1:0];
        end else if (!r_active) begin
            res.status = ST_IDLE;
        end else if (i_item.redial_request || (i_item.frame_ready && !discrete)) begin
            res.status = ST_SIGNAL;
            n_active   = 1'b0;
        end else if (dec != '0) begin
            n_remaining = dec;
            res.status  = ST_WAITING;
        end else if (discrete && i_cfg.pwrsave_enable && win_hit) begin
            n_remaining          = WAIT_PWRSAVE - 1'b1;
            res.status           = ST_WAITING;
            res.watchdog_kick    = 1'b1;
            res.watchdog_seconds = WD_PWRSAVE;
            res.inside_window    = 1'b1;
        end else begin
            res.status = ST_TIMEOUT;
            n_active   = 1'b0;
        end
        res.seconds_to_dial = n_active ? $signed({1'b0, n_remaining}) : '1;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 1'b1;
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_first  <= n_first;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_remaining <= n_remaining;
        end
    end

endmodule

// File: rtl/dwt_chk.sv
// ----------------------------------------------------------------------------
// dwt_chk
// Port-level checks on the result stream of the dial wait timer.
// ----------------------------------------------------------------------------
module dwt_chk
    import dwt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0]      status;
    logic [17:0]     seconds;
    logic            kick;
    logic [WD_W-1:0] wd;
    logic            win_flag;

    assign status   = m_axis_tdata[1:0];
    assign seconds  = m_axis_tdata[19:2];
    assign kick     = m_axis_tdata[20];
    assign wd       = m_axis_tdata[37:21];
    assign win_flag = m_axis_tdata[38];

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no wait running means the time-to-dial reads minus one
    a_idle_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (status == ST_IDLE || status == ST_SIGNAL || status == ST_TIMEOUT)
        |-> seconds == 18'h3FFFF)
        else $error("time-to-dial not minus one after wait ended");

    // a watchdog kick only comes with a running wait
    a_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && kick |-> status == ST_WAITING && seconds != 18'h3FFFF)
        else $error("watchdog kick without running wait");

    // window reload kicks with the fixed power-save timeout
    a_win_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && win_flag |-> kick && wd == WD_PWRSAVE && seconds == 18'd599)
        else $error("window reload with wrong values");

    a_no_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !kick |-> wd == '0 && !win_flag)
        else $error("watchdog value without kick");

endmodule

bind dial_wait_timer_power_save dwt_chk u_dwt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/dial_wait_timer_power_save_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dial_wait_timer_power_save_test
// Self-checking bench for the dial wait timer.
// ----------------------------------------------------------------------------
// Start and tick transactions go in on the slave stream. A behavioral copy
// of the countdown works out the result of every accepted transaction. Each
// result on the master stream is compared field by field with the oldest
// outstanding one. Short directed tests come first: the first wait after
// reset, signal ends, a restart, threshold and saturation edges and monitor
// mode. Then comes a receiver hold-off that stalls the input, and then
// random countdowns in normal, monitor and discrete mode, one of them
// reloading inside the power-save window. Both streams idle at random.
// ----------------------------------------------------------------------------
module dial_wait_timer_power_save_test;
    import dwt_pkg::*;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam int   WD_LIMIT    = (1 << WD_W) - 1;
    localparam int   MINUTE_MAX  = (1 << MINUTE_W) - 1;
    localparam int   INTV_MAX    = (1 << INTERVAL_W) - 1;
    localparam int   RANDOM_ITEMS = 1500;
    localparam int   HOLD_CYCLES = 300;
    localparam int   MAX_REPORTS = 10;
    localparam int   DRAIN_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [0] redial_request, [1] frame_ready, [12:2] now_minutes, [15:13] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] op
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [1:0] status, [19:2] seconds_to_dial, [20] watchdog_kick,
    // [37:21] watchdog_seconds, [38] inside_window, [39] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    dial_wait_timer_power_save dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // register copies and countdown state of the timer model
    logic [INTERVAL_W-1:0] cfg_interval;
    logic                  cfg_monitor;
    logic                  cfg_psave_en;
    logic [MINUTE_W-1:0]   cfg_psave_start;
    logic [MINUTE_W-1:0]   cfg_psave_stop;
    int                    secs_left;
    bit                    first_wait_pending;
    bit                    wait_running;

    t_result pending_results[$];
    int      mismatches;
    int      items_sent;
    int      hold_left;
    bit      tx_quiet;
    bit      rx_quiet;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic bit is_discrete();
        return cfg_interval > DISCRETE_THRESHOLD;
    endfunction

    // window may wrap past midnight; equal bounds mean an empty window
    function automatic bit in_psave_window(logic [MINUTE_W-1:0] now);
        if (cfg_psave_start < cfg_psave_stop) begin
            return (now > cfg_psave_start) && (now <= cfg_psave_stop);
        end
        if (cfg_psave_stop < cfg_psave_start) begin
            return (now <= cfg_psave_stop) || (now > cfg_psave_start);
        end
        return 1'b0;
    endfunction

    function automatic t_result timer_next(logic op, logic redial, logic frame,
                                           logic [MINUTE_W-1:0] now);
        t_result r;
        int      w;
        r = '0;
        r.status = ST_IDLE;
        if (op == OP_START) begin
            if (first_wait_pending) begin
                w = WAIT_FIRST;
                first_wait_pending = 1'b0;
            end else if (cfg_monitor) begin
                w = WAIT_DEFAULT;
            end else if (is_discrete()) begin
                w = cfg_interval;
            end else begin
                w = WAIT_DEFAULT;
            end
            // counter is decremented before the first wait
            secs_left = w - 1;
            wait_running = 1'b1;
            r.status = ST_WAITING;
            r.watchdog_kick = 1'b1;
            r.watchdog_seconds = (w + WD_MARGIN > WD_LIMIT) ? WD_W'(WD_LIMIT)
                                                            : WD_W'(w + WD_MARGIN);
        end else if (!wait_running) begin
            r.status = ST_IDLE;
        end else if (redial || (frame && !is_discrete())) begin
            r.status = ST_SIGNAL;
            wait_running = 1'b0;
        end else begin
            secs_left = secs_left - 1;
            if (secs_left > 0) begin
                r.status = ST_WAITING;
            end else if (is_discrete() && cfg_psave_en && in_psave_window(now)) begin
                secs_left = WAIT_PWRSAVE - 1;
                r.status = ST_WAITING;
                r.watchdog_kick = 1'b1;
                r.watchdog_seconds = WD_PWRSAVE;
                r.inside_window = 1'b1;
            end else begin
                r.status = ST_TIMEOUT;
                wait_running = 1'b0;
            end
        end
        if (!wait_running) begin
            secs_left = -1;
        end
        r.seconds_to_dial = secs_left[SECONDS_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic op, input logic redial, input logic frame,
                             input logic [MINUTE_W-1:0] now);
        @(negedge i_clk);
        while (!tx_quiet && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, now, frame, redial};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(timer_next(op, redial, frame, now));
        items_sent++;
    endtask

    // writes all five registers once the pipeline has drained
    task automatic write_regs(input logic [INTERVAL_W-1:0] interval, input logic mon,
                              input logic pse, input logic [MINUTE_W-1:0] win_start,
                              input logic [MINUTE_W-1:0] win_stop);
        logic [CFG_IDX_W-1:0]  idx[5];
        logic [CFG_DATA_W-1:0] val[5];
        idx = '{CFG_DIAL_INTERVAL, CFG_MONITOR_MODE, CFG_PWRSAVE_EN,
                CFG_PWRSAVE_START, CFG_PWRSAVE_END};
        val = '{interval, CFG_DATA_W'(mon), CFG_DATA_W'(pse),
                CFG_DATA_W'(win_start), CFG_DATA_W'(win_stop)};
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        for (int k = 0; k < 5; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cfg_interval    = interval;
        cfg_monitor     = mon;
        cfg_psave_en    = pse;
        cfg_psave_start = win_start;
        cfg_psave_stop  = win_stop;
    endtask

    function automatic logic [MINUTE_W-1:0] pick_minute();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MINUTE_W'(MINUTE_MAX);
            2: return MINUTE_W'(1439);
            default: return MINUTE_W'($urandom_range(0, MINUTE_MAX));
        endcase
    endfunction

    // time of day on the requested side of the window, where one exists
    function automatic logic [MINUTE_W-1:0] pick_now(bit want_inside);
        logic [MINUTE_W-1:0] n;
        n = '0;
        for (int k = 0; k < 200; k++) begin
            n = MINUTE_W'($urandom_range(0, MINUTE_MAX));
            if (in_psave_window(n) == want_inside) begin
                return n;
            end
        end
        // the window end always lies inside a non-empty window
        if (want_inside && in_psave_window(cfg_psave_stop)) begin
            return cfg_psave_stop;
        end
        return n;
    endfunction

    task automatic test_first_wait();
        // tick with no wait running, signals set
        send_item(OP_TICK, 1'b1, 1'b1, '0);
        // signals are ignored on a start
        send_item(OP_START, 1'b1, 1'b1, MINUTE_W'(MINUTE_MAX));
        repeat (9) send_item(OP_TICK, 1'b0, 1'b0, MINUTE_W'($urandom_range(0, 1) * MINUTE_MAX));
    endtask

    task automatic test_signal_ends();
        send_item(OP_START, 1'b0, 1'b0, 11'd5);
        send_item(OP_TICK, 1'b0, 1'b1, 11'd5);
        send_item(OP_START, 1'b0, 1'b0, 11'd6);
        send_item(OP_TICK, 1'b1, 1'b1, 11'd6);
        // restart while a wait is running
        send_item(OP_START, 1'b0, 1'b0, 11'd7);
        send_item(OP_TICK, 1'b0, 1'b0, 11'd7);
        send_item(OP_START, 1'b0, 1'b0, 11'd8);
        send_item(OP_TICK, 1'b1, 1'b0, 11'd8);
    endtask

    task automatic test_mode_edges();
        // threshold itself is not discrete
        write_regs(17'd900, 1'b0, 1'b0, '0, '0);
        send_item(OP_START, 1'b0, 1'b0, '0);
        send_item(OP_TICK, 1'b0, 1'b1, '0);
        // widest interval saturates the watchdog, ready frame has no effect
        write_regs(INTERVAL_W'(INTV_MAX), 1'b0, 1'b1, MINUTE_W'(MINUTE_MAX), '0);
        send_item(OP_START, 1'b0, 1'b0, '0);
        send_item(OP_TICK, 1'b0, 1'b1, MINUTE_W'(MINUTE_MAX));
        send_item(OP_TICK, 1'b1, 1'b0, '0);
        // monitor mode wins over discrete mode
        write_regs(INTERVAL_W'(INTV_MAX), 1'b1, 1'b1, '0, MINUTE_W'(MINUTE_MAX));
        send_item(OP_START, 1'b0, 1'b0, '0);
        send_item(OP_TICK, 1'b1, 1'b1, '0);
    endtask

    task automatic test_backpressure();
        write_regs('0, 1'b0, 1'b0, '0, '0);
        send_item(OP_START, 1'b0, 1'b0, 11'd100);
        hold_left = HOLD_CYCLES;
        repeat (40) send_item(OP_TICK, 1'b0, 1'b0, MINUTE_W'($urandom_range(0, MINUTE_MAX)));
        send_item(OP_TICK, 1'b1, 1'b0, 11'd100);
    endtask

    task automatic run_random_phase(input int phase);
        bit  discrete_run;
        bit  forced_reload;
        bit  mon;
        bit  pse;
        bit  redial;
        bit  frame;
        int  ticks;
        int  redial_odds;
        int  frame_odds;
        logic [INTERVAL_W-1:0] interval;
        logic [MINUTE_W-1:0]   win_start;
        logic [MINUTE_W-1:0]   win_stop;
        logic [MINUTE_W-1:0]   now;

        forced_reload = (phase == 3);
        discrete_run = forced_reload || ($urandom_range(0, 99) < 8);
        win_start = pick_minute();
        win_stop = pick_minute();
        if (discrete_run) begin
            mon = 1'b0;
            interval = INTERVAL_W'($urandom_range(901, 912));
            pse = forced_reload || ($urandom_range(0, 99) < 85);
            if (forced_reload) begin
                win_start = MINUTE_W'($urandom_range(0, 1023));
                win_stop = win_start + MINUTE_W'($urandom_range(1, 1000));
            end
            redial_odds = 3000;
            frame_odds = 20;
        end else begin
            mon = 1'($urandom_range(0, 1));
            interval = mon ? INTERVAL_W'($urandom_range(0, INTV_MAX))
                           : INTERVAL_W'($urandom_range(0, 900));
            pse = 1'($urandom_range(0, 1));
            redial_odds = 120;
            frame_odds = 120;
        end
        write_regs(interval, mon, pse, win_start, win_stop);

        send_item(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  pick_minute());
        // the forced discrete run is long, so it runs without idling
        if (phase == 3) begin
            tx_quiet = 1'b1;
            rx_quiet = 1'b1;
        end
        ticks = 0;
        while (wait_running && ticks < 3000) begin
            redial = !forced_reload && ($urandom_range(1, redial_odds) == 1);
            frame = $urandom_range(1, frame_odds) == 1;
            now = MINUTE_W'($urandom_range(0, MINUTE_MAX));
            if (discrete_run && secs_left == 1) begin
                // the next tick reaches zero: steer the window check
                now = pick_now(forced_reload ? 1'b1 : ($urandom_range(0, 99) < 30));
                forced_reload = 1'b0;
            end
            if (!discrete_run && $urandom_range(0, 299) == 0) begin
                send_item(OP_START, redial, frame, now);
            end else begin
                send_item(OP_TICK, redial, frame, now);
            end
            ticks++;
        end
        // noise once the wait is over
        repeat ($urandom_range(0, 3)) begin
            send_item(($urandom_range(0, 3) == 0) ? OP_START : OP_TICK,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      MINUTE_W'($urandom_range(0, MINUTE_MAX)));
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_random();
        int first_item;
        int phase;
        first_item = items_sent;
        phase = 0;
        while (items_sent - first_item < RANDOM_ITEMS || phase < 8) begin
            run_random_phase(phase);
            phase++;
        end
    endtask

    // receiver side: random stalls, one long hold-off counted here
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= rx_quiet || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result %h with no transaction outstanding",
                             $realtime, m_axis_tdata);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status
                        || m_axis_tdata[19:2] !== want.seconds_to_dial
                        || m_axis_tdata[20] !== want.watchdog_kick
                        || m_axis_tdata[37:21] !== want.watchdog_seconds
                        || m_axis_tdata[38] !== want.inside_window) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display({"%0t: expected status %0d secs %0d kick %0b wd %0d in %0b,",
                                  " got status %0d secs %0d kick %0b wd %0d in %0b"},
                                 $realtime, want.status, want.seconds_to_dial,
                                 want.watchdog_kick, want.watchdog_seconds,
                                 want.inside_window, m_axis_tdata[1:0],
                                 $signed(m_axis_tdata[19:2]), m_axis_tdata[20],
                                 m_axis_tdata[37:21], m_axis_tdata[38]);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int drain_cycles;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        cfg_interval    = '0;
        cfg_monitor     = 1'b0;
        cfg_psave_en    = 1'b0;
        cfg_psave_start = '0;
        cfg_psave_stop  = '0;
        secs_left          = -1;
        first_wait_pending = 1'b1;
        wait_running       = 1'b0;
        mismatches = 0;
        items_sent = 0;
        hold_left  = 0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_wait();
        test_signal_ends();
        test_mode_edges();
        test_backpressure();
        test_random();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
        end
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/dwt_pkg.sv
rtl/dwt_cfg.sv
rtl/dwt_core.sv
rtl/dial_wait_timer_power_save.sv
rtl/dwt_chk.sv
test/dial_wait_timer_power_save_test.sv
